>>> design/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types for the complex arithmetic unit: operation codes and the
// request and result payloads.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_BITS = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_NEQ = 3'd5,
        OP_MAX = 3'd6,
        OP_MIN = 3'd7
    } t_op;

    typedef struct packed {
        t_op                          req_type;
        logic signed [WORD_BITS-1:0]  a_real;
        logic signed [WORD_BITS-1:0]  a_imag;
        logic signed [WORD_BITS-1:0]  b_real;
        logic signed [WORD_BITS-1:0]  b_imag;
    } t_req;

    typedef struct packed {
        logic signed [WORD_BITS-1:0]  res_real;
        logic signed [WORD_BITS-1:0]  res_imag;
        logic                         div_by_zero;
        logic                         saturated;
    } t_res;

endpackage

>>> design/complex_arith_unit_top.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// Pipelined complex ALU in signed fixed point: add, sub, mul, div, compares
// and magnitude max/min, with saturation and a near-zero divisor check.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the output is not stalled. Four
// stages form products, sums and the non-divide results, then a restoring
// divider retires one quotient bit per stage (plus one stage for the overflow
// check) for both parts at once, and a last stage saturates. A stall on the
// output freezes the whole pipeline; o_stall follows it. The near-zero
// threshold resets to 1; the user must write it with i_cfg_we only while no
// request is in flight, as the block does not enforce this.
module complex_arith_unit_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata,
    input  logic            i_valid,
    output logic            o_stall,
    input  cau_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output cau_pkg::t_res   o_res
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int SW = 2*W + 4;
    localparam int RW = 3*W + FRAC_BITS + 4;

    localparam logic signed [SW-1:0] C_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] C_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] C_ONE = SW'(1) << FRAC_BITS;

    typedef struct packed {
        logic [RW-1:0]  rem_re;
        logic [RW-1:0]  rem_im;
        logic [W-1:0]   q_re;
        logic [W-1:0]   q_im;
        logic           ovf_re;
        logic           ovf_im;
        logic           neg_re;
        logic           neg_im;
        logic [SW-1:0]  den;
        logic           is_div;
        logic           dz;
        logic [W-1:0]   res_re;
        logic [W-1:0]   res_im;
        logic           sat;
    } t_dv;

    function automatic logic signed [SW-1:0] f_round(input logic signed [SW-1:0] x);
        logic [SW-1:0] m;
        m = x[SW-1] ? -x : x;
        m = (m + (SW'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        return x[SW-1] ? $signed(-m) : $signed(m);
    endfunction

    // {sat, value}
    function automatic logic [W:0] f_clamp(input logic signed [SW-1:0] x);
        if (x > C_MAX) begin
            return {1'b1, C_MAX[W-1:0]};
        end else if (x < C_MIN) begin
            return {1'b1, C_MIN[W-1:0]};
        end
        return {1'b0, x[W-1:0]};
    endfunction

    logic en;
    logic r_e_vld;
    t_res r_e;

    assign en      = !r_e_vld || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_e_vld;
    assign o_res   = r_e;

    // near-zero threshold
    logic [15:0] r_eps;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 16'd1;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // stage a: input register
    logic r_a_vld;
    t_req r_a;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= i_req;
        end
    end

    // stage b: products and squares
    logic                   r_b_vld;
    t_req                   r_b;
    logic signed [2*W-1:0]  r_b_p1, r_b_p2, r_b_p3, r_b_p4;
    logic signed [2*W-1:0]  r_b_sar, r_b_sai, r_b_sbr, r_b_sbi;
    logic signed [2*W+1:0]  r_b_sdr, r_b_sdi;
    logic signed [W:0]      r_b_asr, r_b_asi;
    logic [31:0]            r_b_eps2;
    logic signed [W:0]      dr, di;

    assign dr = $signed({r_a.a_real[W-1], r_a.a_real}) - $signed({r_a.b_real[W-1], r_a.b_real});
    assign di = $signed({r_a.a_imag[W-1], r_a.a_imag}) - $signed({r_a.b_imag[W-1], r_a.b_imag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b     <= r_a;
            r_b_p1  <= r_a.a_real * r_a.b_real;
            r_b_p2  <= r_a.a_imag * r_a.b_imag;
            r_b_p3  <= r_a.a_real * r_a.b_imag;
            r_b_p4  <= r_a.a_imag * r_a.b_real;
            r_b_sar <= r_a.a_real * r_a.a_real;
            r_b_sai <= r_a.a_imag * r_a.a_imag;
            r_b_sbr <= r_a.b_real * r_a.b_real;
            r_b_sbi <= r_a.b_imag * r_a.b_imag;
            r_b_sdr <= dr * dr;
            r_b_sdi <= di * di;
            r_b_eps2 <= r_eps * r_eps;
            if (r_a.req_type == OP_SUB) begin
                r_b_asr <= dr;
                r_b_asi <= di;
            end else begin
                r_b_asr <= $signed({r_a.a_real[W-1], r_a.a_real})
                         + $signed({r_a.b_real[W-1], r_a.b_real});
                r_b_asi <= $signed({r_a.a_imag[W-1], r_a.a_imag})
                         + $signed({r_a.b_imag[W-1], r_a.b_imag});
            end
        end
    end

    // stage c: sums of products
    logic                   r_c_vld;
    t_req                   r_c;
    logic signed [SW-1:0]   r_c_mre, r_c_mim, r_c_nre, r_c_nim;
    logic signed [SW-1:0]   r_c_den, r_c_ma, r_c_d2;
    logic signed [W:0]      r_c_asr, r_c_asi;
    logic [31:0]            r_c_eps2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c      <= r_b;
            r_c_mre  <= SW'(r_b_p1) - SW'(r_b_p2);
            r_c_mim  <= SW'(r_b_p3) + SW'(r_b_p4);
            r_c_nre  <= SW'(r_b_p1) + SW'(r_b_p2);
            r_c_nim  <= SW'(r_b_p4) - SW'(r_b_p3);
            r_c_den  <= SW'(r_b_sbr) + SW'(r_b_sbi);
            r_c_ma   <= SW'(r_b_sar) + SW'(r_b_sai);
            r_c_d2   <= SW'(r_b_sdr) + SW'(r_b_sdi);
            r_c_asr  <= r_b_asr;
            r_c_asi  <= r_b_asi;
            r_c_eps2 <= r_b_eps2;
        end
    end

    // stage d: non-divide results, divider setup
    t_dv                  dv_in;
    logic signed [SW-1:0] val_re, val_im, mag_re, mag_im;
    logic [W:0]           cl_re, cl_im;
    logic                 is_eq, pick_a;

    always_comb begin
        is_eq  = r_c_d2 < SW'(r_c_eps2);
        pick_a = 1'b0;
        val_re = '0;
        val_im = '0;
        unique case (r_c.req_type)
            OP_ADD, OP_SUB: begin
                val_re = SW'(r_c_asr);
                val_im = SW'(r_c_asi);
            end
            OP_MUL: begin
                val_re = f_round(r_c_mre);
                val_im = f_round(r_c_mim);
            end
            OP_DIV: begin
                val_re = '0;
                val_im = '0;
            end
            OP_EQ, OP_NEQ: begin
                val_re = (is_eq == (r_c.req_type == OP_EQ)) ? C_ONE : '0;
            end
            OP_MAX, OP_MIN: begin
                pick_a = (r_c.req_type == OP_MAX) ? (r_c_ma > r_c_den) : (r_c_ma < r_c_den);
                val_re = pick_a ? SW'(r_c.a_real) : SW'(r_c.b_real);
                val_im = pick_a ? SW'(r_c.a_imag) : SW'(r_c.b_imag);
            end
            default: begin
                val_re = '0;
            end
        endcase
        cl_re  = f_clamp(val_re);
        cl_im  = f_clamp(val_im);
        mag_re = r_c_nre[SW-1] ? -r_c_nre : r_c_nre;
        mag_im = r_c_nim[SW-1] ? -r_c_nim : r_c_nim;

        dv_in.rem_re = (RW'(mag_re) << FRAC_BITS) + (RW'(r_c_den) >> 1);
        dv_in.rem_im = (RW'(mag_im) << FRAC_BITS) + (RW'(r_c_den) >> 1);
        dv_in.q_re   = '0;
        dv_in.q_im   = '0;
        dv_in.ovf_re = 1'b0;
        dv_in.ovf_im = 1'b0;
        dv_in.neg_re = r_c_nre[SW-1];
        dv_in.neg_im = r_c_nim[SW-1];
        dv_in.den    = r_c_den;
        dv_in.is_div = r_c.req_type == OP_DIV;
        dv_in.dz     = (r_c_den == '0) || (r_c_den < (SW'(r_eps) << FRAC_BITS));
        dv_in.res_re = cl_re[W-1:0];
        dv_in.res_im = cl_im[W-1:0];
        dv_in.sat    = cl_re[W] | cl_im[W];
    end

    logic r_d_vld;
    t_dv  r_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d <= dv_in;
        end
    end

    // restoring divider: overflow check, then one quotient bit per stage
    t_dv  r_dv     [W+1];
    logic r_dv_vld [W+1];

    for (genvar k = 0; k <= W; k++) begin : g_div
        localparam int BIT = (k == 0) ? W : W - k;
        t_dv           src, n_dv;
        logic          src_vld;
        logic [RW-1:0] d_sh;

        if (k == 0) begin : g_first
            assign src     = r_d;
            assign src_vld = r_d_vld;
        end else begin : g_next
            assign src     = r_dv[k-1];
            assign src_vld = r_dv_vld[k-1];
        end

        assign d_sh = RW'(src.den) << BIT;

        if (k == 0) begin : g_ovf
            always_comb begin
                n_dv = src;
                n_dv.ovf_re = src.rem_re >= d_sh;
                n_dv.ovf_im = src.rem_im >= d_sh;
            end
        end else begin : g_bit
            always_comb begin
                n_dv = src;
                if (src.rem_re >= d_sh) begin
                    n_dv.rem_re = src.rem_re - d_sh;
                    n_dv.q_re[BIT] = 1'b1;
                end
                if (src.rem_im >= d_sh) begin
                    n_dv.rem_im = src.rem_im - d_sh;
                    n_dv.q_im[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (en) begin
                r_dv_vld[k] <= src_vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k] <= n_dv;
            end
        end
    end

    // stage e: quotient saturation and output register
    t_dv        lst;
    t_res       n_e;
    logic [W-1:0] lim_re, lim_im, m_re, m_im;
    logic       s_re, s_im;

    assign lst = r_dv[W];

    always_comb begin
        lim_re = lst.neg_re ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - W'(1));
        lim_im = lst.neg_im ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - W'(1));
        s_re   = lst.ovf_re || (lst.q_re > lim_re);
        s_im   = lst.ovf_im || (lst.q_im > lim_im);
        m_re   = s_re ? lim_re : lst.q_re;
        m_im   = s_im ? lim_im : lst.q_im;
        if (!lst.is_div) begin
            n_e.res_real    = lst.res_re;
            n_e.res_imag    = lst.res_im;
            n_e.div_by_zero = 1'b0;
            n_e.saturated   = lst.sat;
        end else if (lst.dz) begin
            n_e.res_real    = '0;
            n_e.res_imag    = '0;
            n_e.div_by_zero = 1'b1;
            n_e.saturated   = 1'b0;
        end else begin
            n_e.res_real    = lst.neg_re ? -m_re : m_re;
            n_e.res_imag    = lst.neg_im ? -m_im : m_im;
            n_e.div_by_zero = 1'b0;
            n_e.saturated   = s_re | s_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_dv_vld[W];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e <= n_e;
        end
    end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point complex ALU. Requests are queued
// by the stimulus process and sent by a clocked driver. Each transfer is
// scored by an internal predictor that uses exact wide arithmetic, and a
// monitor compares the results in order. The run steps through several
// epsilon settings and through phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
    import cau_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = WORD_BITS + 6;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [15:0]   i_cfg_wdata;
    logic          i_valid;
    logic          o_stall;
    t_req          i_req;
    logic          o_valid;
    logic          i_stall;
    t_res          o_res;

    complex_arith_unit_top #(.FRAC_BITS(FRAC)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (o_res)
    );

    t_req        pending_reqs[$];
    t_res        expected_res[$];
    logic [15:0] eps_shadow;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          errors;
    int          n_checked;
    int          n_dz;
    int          n_sat;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // clamp a sign/magnitude value to the word range
    function automatic logic [WORD_BITS-1:0] clamp_word(input logic neg,
                                                        input logic [127:0] mag,
                                                        inout logic sat);
        logic [127:0] lim;
        logic [127:0] m;
        lim = (128'd1 << (WORD_BITS - 1)) - (neg ? 128'd0 : 128'd1);
        m = mag;
        if (m > lim) begin
            m = lim;
            sat = 1'b1;
        end
        return neg ? -m[WORD_BITS-1:0] : m[WORD_BITS-1:0];
    endfunction

    function automatic logic [127:0] abs128(input logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_res complex_result(input t_req r, input logic [15:0] eps);
        t_res                 res;
        logic signed [127:0]  ar, ai, br, bi, sr, si, den, d2;
        logic [127:0]         mr, mi, den_u;
        logic                 nr, ni, sat, is_eq;
        ar = $signed(r.a_real);
        ai = $signed(r.a_imag);
        br = $signed(r.b_real);
        bi = $signed(r.b_imag);
        sr = 0;
        si = 0;
        sat = 1'b0;
        res = '0;
        case (r.req_type)
            OP_ADD, OP_SUB, OP_MUL: begin
                if (r.req_type == OP_ADD) begin
                    sr = ar + br;
                    si = ai + bi;
                end else if (r.req_type == OP_SUB) begin
                    sr = ar - br;
                    si = ai - bi;
                end else begin
                    sr = ar * br - ai * bi;
                    si = ar * bi + ai * br;
                end
                mr = abs128(sr);
                mi = abs128(si);
                if (r.req_type == OP_MUL) begin
                    // round half away from zero on the magnitude
                    mr = (mr + (128'd1 << (FRAC - 1))) >> FRAC;
                    mi = (mi + (128'd1 << (FRAC - 1))) >> FRAC;
                end
                res.res_real = clamp_word(sr < 0 && mr != 0, mr, sat);
                res.res_imag = clamp_word(si < 0 && mi != 0, mi, sat);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                den_u = den;
                if (den_u == 0 || den_u < ({112'd0, eps} << FRAC)) begin
                    res.div_by_zero = 1'b1;
                end else begin
                    sr = ar * br + ai * bi;
                    si = ai * br - ar * bi;
                    mr = ((abs128(sr) << FRAC) + (den_u >> 1)) / den_u;
                    mi = ((abs128(si) << FRAC) + (den_u >> 1)) / den_u;
                    res.res_real = clamp_word(sr < 0 && mr != 0, mr, sat);
                    res.res_imag = clamp_word(si < 0 && mi != 0, mi, sat);
                end
            end
            OP_EQ, OP_NEQ: begin
                d2 = (ar - br) * (ar - br) + (ai - bi) * (ai - bi);
                is_eq = d2 < $signed({112'd0, eps}) * $signed({112'd0, eps});
                if (is_eq == (r.req_type == OP_EQ))
                    res.res_real = clamp_word(1'b0, 128'd1 << FRAC, sat);
            end
            default: begin
                sr = ar * ar + ai * ai;
                si = br * br + bi * bi;
                if ((r.req_type == OP_MAX) ? (sr > si) : (sr < si)) begin
                    res.res_real = r.a_real;
                    res.res_imag = r.a_imag;
                end else begin
                    res.res_real = r.b_real;
                    res.res_imag = r.b_imag;
                end
            end
        endcase
        res.saturated = sat;
        return res;
    endfunction

    // driver: one nonblocking update of valid per edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_res.push_back(complex_result(i_req, eps_shadow));
            if (!i_valid || !o_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_req <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_res.size() == 0) begin
                $error("result transfer with no expectation: real %0d imag %0d",
                       o_res.res_real, o_res.res_imag);
                errors++;
            end else begin
                t_res e;
                e = expected_res.pop_front();
                n_checked++;
                if (e.div_by_zero) n_dz++;
                if (e.saturated) n_sat++;
                if (o_res.res_real !== e.res_real) begin
                    $error("res_real expected %0d got %0d", e.res_real, o_res.res_real);
                    errors++;
                end
                if (o_res.res_imag !== e.res_imag) begin
                    $error("res_imag expected %0d got %0d", e.res_imag, o_res.res_imag);
                    errors++;
                end
                if (o_res.div_by_zero !== e.div_by_zero) begin
                    $error("div_by_zero expected %0b got %0b", e.div_by_zero,
                           o_res.div_by_zero);
                    errors++;
                end
                if (o_res.saturated !== e.saturated) begin
                    $error("saturated expected %0b got %0b", e.saturated, o_res.saturated);
                    errors++;
                end
            end
        end
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 3) - 1;
            4: return 32'($signed($urandom_range(0, 600)) - 300);
            5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            6: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req make_req(input t_op op, input logic [31:0] ar,
                                      input logic [31:0] ai, input logic [31:0] br,
                                      input logic [31:0] bi);
        t_req r;
        r.req_type = op;
        r.a_real = ar;
        r.a_imag = ai;
        r.b_real = br;
        r.b_imag = bi;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        r = make_req(t_op'($urandom_range(0, 7)), pick_word(), pick_word(),
                     pick_word(), pick_word());
        case ($urandom_range(0, 5))
            // b close to a, for compares and magnitude ties
            0: begin
                r.b_real = r.a_real + 32'($signed($urandom_range(0, 400)) - 200);
                r.b_imag = r.a_imag + 32'($signed($urandom_range(0, 400)) - 200);
            end
            1: begin
                r.b_real = r.a_imag;
                r.b_imag = r.a_real;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || i_valid || expected_res.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_eps(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        eps_shadow <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    logic [15:0] eps_plan[7] = '{16'd0, 16'd65535, 16'd256, 16'd1, 16'd40000, 16'd7, 16'd0};
    int          idle_plan[7] = '{0, 1, 2, 3, 0, 3, 1};

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req = '0;
        eps_shadow = 16'd1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0;
        n_checked = 0;
        n_dz = 0;
        n_sat = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every op, zero divisor, ties, saturation
        pending_reqs.push_back(make_req(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h8000_0000));
        pending_reqs.push_back(make_req(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000));
        pending_reqs.push_back(make_req(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'd5, 32'd0));
        pending_reqs.push_back(make_req(OP_MUL, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000));
        pending_reqs.push_back(make_req(OP_MUL, 32'h0001_8000, 32'h0000_8000,
                                        32'h0000_8000, 32'hFFFF_8000));
        pending_reqs.push_back(make_req(OP_MUL, 32'd1, 32'd0, 32'h0000_8000, 32'd0));
        pending_reqs.push_back(make_req(OP_MUL, 32'hFFFF_FFFF, 32'd0, 32'h0000_8000, 32'd0));
        pending_reqs.push_back(make_req(OP_DIV, 32'h0001_0000, 32'd0, 32'd0, 32'd0));
        pending_reqs.push_back(make_req(OP_DIV, 32'h7FFF_FFFF, 32'd3, 32'd1, 32'd0));
        pending_reqs.push_back(make_req(OP_DIV, 32'h0003_0000, 32'h0001_0000,
                                        32'h0002_0000, 32'hFFFF_0000));
        pending_reqs.push_back(make_req(OP_DIV, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000));
        pending_reqs.push_back(make_req(OP_DIV, 32'd12345, 32'd0, 32'd256, 32'd0));
        pending_reqs.push_back(make_req(OP_EQ, 32'd100, 32'd7, 32'd100, 32'd7));
        pending_reqs.push_back(make_req(OP_EQ, 32'd100, 32'd7, 32'd101, 32'd7));
        pending_reqs.push_back(make_req(OP_NEQ, 32'd100, 32'd7, 32'd100, 32'd7));
        pending_reqs.push_back(make_req(OP_NEQ, 32'h8000_0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_reqs.push_back(make_req(OP_MAX, 32'd3, 32'd4, 32'd4, 32'hFFFF_FFFD));
        pending_reqs.push_back(make_req(OP_MIN, 32'd3, 32'd4, 32'd5, 32'd0));
        pending_reqs.push_back(make_req(OP_MAX, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0));
        pending_reqs.push_back(make_req(OP_MIN, 32'd1, 32'd1, 32'd2, 32'd2));
        pending_reqs.push_back(make_req(OP_MIN, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0));
        drain();

        for (int p = 0; p < 7; p++) begin
            // sender holds off here until every result has come back
            drain();
            write_eps(p == 6 ? 16'($urandom_range(0, 65535)) : eps_plan[p]);
            case (idle_plan[p])
                1: begin send_idle_pct = 58; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 58; end
                3: begin send_idle_pct = 26; recv_stall_pct = 26; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int k = 0; k < 265; k++)
                pending_reqs.push_back(random_req());
        end
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("tb_top: %0d results checked over 8 epsilon settings and 4 idling patterns",
                 n_checked);
        $display("tb_top: %0d near-zero divides, %0d saturated results", n_dz, n_sat);
        if (errors == 0 && expected_res.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
design/cau_pkg.sv
design/complex_arith_unit_top.sv
sim/tb_top.sv
